FILE: hw/rtl/msgpack_int_unpacker_macros.svh
// Assertion macros for the MessagePack integer unpacker.
`ifndef MSGPACK_INT_UNPACKER_MACROS_SVH
`define MSGPACK_INT_UNPACKER_MACROS_SVH
`ifndef SYNTH
// Check on an explicit clock and active-low reset.
`define MIU_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("msgpack_int_unpacker assertion failed");
// Check on the block clock and reset.
`define MIU_ASSERT(label, prop) \
    `MIU_ASSERT_CLK(label, i_clk, i_rst_n, prop)
`else
`define MIU_ASSERT_CLK(label, clk, rst_n, prop)
`define MIU_ASSERT(label, prop)
`endif
`endif

FILE: hw/rtl/miu_pkg.sv
// Types, constants and helpers shared by the MessagePack integer unpacker.
package miu_pkg;

    localparam logic [63:0] MAX_S8  = 64'h0000_0000_0000_007f;
    localparam logic [63:0] MAX_S16 = 64'h0000_0000_0000_7fff;
    localparam logic [63:0] MAX_S32 = 64'h0000_0000_7fff_ffff;
    localparam logic [63:0] MAX_S64 = 64'h7fff_ffff_ffff_ffff;

    // Header bytes
    localparam logic [7:0] HDR_UINT8   = 8'hcc;
    localparam logic [7:0] HDR_INT8    = 8'hd0;
    localparam logic [7:0] HDR_NEG_FIX = 8'he0;

    // Register indexes
    localparam logic [1:0] REG_TARGET_SIGNED = 2'd0;
    localparam logic [1:0] REG_TARGET_WIDTH  = 2'd1;

    // Payload size codes
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FORMAT = 2'd1,
        ST_RANGE      = 2'd2
    } t_status;

    // What to do with the payload once it is complete
    typedef enum logic [1:0] {
        ACT_ZEXT     = 2'd0,
        ACT_SEXT     = 2'd1,
        ACT_TOPCLEAR = 2'd2
    } t_action;

    typedef struct packed {
        logic       tgt_signed;
        logic [1:0] width_code;
    } t_cfg;

    typedef struct packed {
        logic        collecting;
        t_action     kind;
        logic [3:0]  bytes_left;
        logic [63:0] acc;
        logic [3:0]  obj_len;
    } t_state;

    typedef struct packed {
        logic [63:0] int_value;
        t_status     status;
        logic [3:0]  consumed_len;
    } t_result;

    function automatic logic [63:0] int_max(input logic [1:0] sz);
        logic [63:0] m;
        unique case (sz)
            SZ_8:    m = MAX_S8;
            SZ_16:   m = MAX_S16;
            SZ_32:   m = MAX_S32;
            default: m = MAX_S64;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/miu_if.sv
// Channel interfaces: stream bytes, results and register writes.
interface miu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface miu_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] int_value;
    logic [1:0]  status;
    logic [3:0]  consumed_len;
    modport source (output valid, output int_value, output status, output consumed_len,
                    input ready);
    modport sink   (input valid, input int_value, input status, input consumed_len,
                    output ready);
endinterface

interface miu_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    logic [1:0] wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: hw/rtl/miu_decode.sv
// One-byte decode step: header classification, payload gathering and final range check.
module miu_decode import miu_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_state     o_state,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [63:0] acc_sh;
    logic [3:0]  bl_dec;
    logic [1:0]  code;
    logic [1:0]  fsz;
    logic        over;
    logic [63:0] ext_val;
    logic [3:0]  start_bl;

    always_comb begin
        acc_sh = {i_state.acc[55:0], i_byte};
        bl_dec = i_state.bytes_left - 4'd1;
        code   = i_byte[1:0];

        // payload size recovered from the object length
        unique case (i_state.obj_len)
            4'd2:    fsz = SZ_8;
            4'd3:    fsz = SZ_16;
            4'd5:    fsz = SZ_32;
            default: fsz = SZ_64;
        endcase
        // acc holds only payload bits, so above-max means top bit set
        over = (acc_sh > int_max(fsz));

        unique case (fsz)
            SZ_8:    ext_val = {{56{acc_sh[7]}}, acc_sh[7:0]};
            SZ_16:   ext_val = {{48{acc_sh[15]}}, acc_sh[15:0]};
            SZ_32:   ext_val = {{32{acc_sh[31]}}, acc_sh[31:0]};
            default: ext_val = acc_sh;
        endcase

        unique case (code)
            SZ_8:    start_bl = 4'd1;
            SZ_16:   start_bl = 4'd2;
            SZ_32:   start_bl = 4'd4;
            default: start_bl = 4'd8;
        endcase

        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '{int_value: '0, status: ST_OK, consumed_len: '0};

        if (i_state.collecting) begin
            o_state.acc        = acc_sh;
            o_state.bytes_left = bl_dec;
            if (bl_dec == 4'd0) begin
                o_state.collecting = 1'b0;
                o_res_valid        = 1'b1;
                if (i_state.kind == ACT_TOPCLEAR && over) begin
                    o_res.status = ST_RANGE;
                end else begin
                    o_res.int_value    = (i_state.kind == ACT_SEXT) ? ext_val : acc_sh;
                    o_res.consumed_len = i_state.obj_len;
                end
            end
        end else if (!i_byte[7]) begin
            o_res_valid        = 1'b1;
            o_res.int_value    = {56'd0, i_byte};
            o_res.consumed_len = 4'd1;
        end else if (i_byte >= HDR_NEG_FIX) begin
            o_res_valid = 1'b1;
            if (i_cfg.tgt_signed) begin
                o_res.int_value    = {56'hff_ffff_ffff_ffff, i_byte};
                o_res.consumed_len = 4'd1;
            end else begin
                o_res.status = ST_RANGE;
            end
        end else if (i_byte[7:2] == HDR_UINT8[7:2] || i_byte[7:2] == HDR_INT8[7:2]) begin
            if (code > i_cfg.width_code) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_BAD_FORMAT;
            end else begin
                o_state.collecting = 1'b1;
                o_state.bytes_left = start_bl;
                o_state.obj_len    = start_bl + 4'd1;
                o_state.acc        = '0;
                if (i_byte[7:2] == HDR_UINT8[7:2]) begin
                    // unsigned source into a signed target of the same width
                    o_state.kind = (i_cfg.tgt_signed && code == i_cfg.width_code)
                                   ? ACT_TOPCLEAR : ACT_ZEXT;
                end else begin
                    o_state.kind = i_cfg.tgt_signed ? ACT_SEXT : ACT_TOPCLEAR;
                end
            end
        end else begin
            o_res_valid  = 1'b1;
            o_res.status = ST_BAD_FORMAT;
        end
    end

endmodule

FILE: hw/rtl/msgpack_int_unpacker.sv
// MessagePack integer unpacker: stream bytes in, decoded integers out.
//
// Channels: i_in takes one MessagePack byte per request; o_res gives one
// result per finished or rejected object (value, status, consumed length);
// i_cfg writes the target type (index 0 signedness, index 1 width code).
// Write i_cfg only while no object is in flight.
// A byte in the input register is decoded into the result register when the
// decode stage advances, and its result is then on o_res.
// Throughput: one byte per cycle while o_res takes results; payload bytes
// before the last of an object produce no result. The rate is set by the
// one-byte shift and 64-bit range compare between input and result registers.
// Reset: parser returns to waiting for a header, pipeline empties, target
// becomes signed 64-bit.
// Stall: when o_res holds an unaccepted result, the decode stage waits and
// i_in.ready drops once the input register is full too; nothing is lost.
// Config port is always ready.
`include "msgpack_int_unpacker_macros.svh"
module msgpack_int_unpacker import miu_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    miu_cfg_if.sink    i_cfg,
    miu_byte_if.sink   i_in,
    miu_res_if.source  o_res
);

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_res;
    t_result    n_res;
    logic       n_res_valid;
    logic       advance;

    miu_decode u_decode (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .i_cfg       (r_cfg),
        .o_state     (n_state),
        .o_res_valid (n_res_valid),
        .o_res       (n_res)
    );

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid        = r_out_valid;
    assign o_res.int_value    = r_res.int_value;
    assign o_res.status       = r_res.status;
    assign o_res.consumed_len = r_res.consumed_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '{tgt_signed: 1'b1, width_code: SZ_64};
            r_state     <= '{collecting: 1'b0, kind: ACT_ZEXT, bytes_left: '0,
                             acc: '0, obj_len: '0};
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.reg_index)
                    REG_TARGET_SIGNED: r_cfg.tgt_signed <= i_cfg.wr_data[0];
                    REG_TARGET_WIDTH:  r_cfg.width_code <= i_cfg.wr_data;
                    default: ;
                endcase
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= n_res_valid;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
        if (advance && n_res_valid) begin
            r_res <= n_res;
        end
    end

    `MIU_ASSERT(a_err_clears_payload,
        (r_out_valid && r_res.status != ST_OK) |->
            (r_res.int_value == 64'd0 && r_res.consumed_len == 4'd0))
    `MIU_ASSERT(a_ok_len_legal,
        (r_out_valid && r_res.status == ST_OK) |->
            (r_res.consumed_len == 4'd1 || r_res.consumed_len == 4'd2 ||
             r_res.consumed_len == 4'd3 || r_res.consumed_len == 4'd5 ||
             r_res.consumed_len == 4'd9))
    `MIU_ASSERT(a_collect_count,
        r_state.collecting |->
            (r_state.bytes_left != 4'd0 && r_state.bytes_left <= 4'd8 &&
             r_state.obj_len > r_state.bytes_left))

endmodule
